FILE: hdl/tlbl_pkg.sv
package tlbl_pkg;

   localparam int ADDR_BITS = 16;

   // rsp_tuser bit positions
   localparam int HIT_BIT   = 0;
   localparam int FAULT_BIT = 1;
   localparam int USER_BITS = 2;

endpackage

FILE: hdl/tlbl_ram.sv
module tlbl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/tlbl_page_mod.sv
module tlbl_page_mod #(
   parameter int OFFSET_BITS = 8,
   parameter int PAGE_COUNT  = 256
) (
   input  logic                                     clock,
   input  logic [tlbl_pkg::ADDR_BITS-OFFSET_BITS-1:0] page_raw,
   output logic [$clog2(PAGE_COUNT)-1:0]            page
);

   import tlbl_pkg::*;

   localparam int NB  = ADDR_BITS - OFFSET_BITS;
   localparam int PIB = $clog2(PAGE_COUNT);

   logic [PIB-1:0] page_ff;
   logic [PIB-1:0] page_in;

   generate
      if (PAGE_COUNT >= 2 ** NB) begin : g_direct
         assign page_in = PIB'(page_raw);
      end else begin : g_reduce
         // quotient by reciprocal multiply, exact for every NB-bit page
         localparam int SHIFT = NB + PIB;
         localparam int MULT  = (2 ** SHIFT) / PAGE_COUNT + 1;
         localparam int MB    = NB + 2;
         localparam int PB    = NB + MB;

         logic [PB-1:0] prod_ff;
         logic [PB-1:0] prod_in;
         logic [NB-1:0] quot;
         logic [NB-1:0] rem;

         assign prod_in = PB'(page_raw) * PB'(MULT);
         assign quot    = NB'(prod_ff >> SHIFT);
         assign rem     = page_raw - NB'(quot * PAGE_COUNT);
         assign page_in = PIB'(rem);

         always_ff @(posedge clock) begin
            prod_ff <= prod_in;
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      page_ff <= page_in;
   end

   assign page = page_ff;

endmodule

FILE: hdl/tlb_lru_address_translate_unit.sv
// Virtual to physical address translation with an LRU-managed TLB.
// req channel: one virtual address per item (page in the upper bits, offset
// in the lower OFFSET_BITS). rsp channel: one item per request carrying the
// physical address in tdata and the TLB hit and page fault flags in tuser.
// Each request is reduced to a page index, then one compare unit walks the
// TLB one entry a cycle, finding the matching entry and the LRU victim in
// the same pass. The commit state then updates ages, the TLB entry on a miss and the page map on a page fault.
// The TLB walk follows the page reduction (ST_MUL, ST_MOD) and the result is
// registered at commit; req_tready is low from accept until the commit is
// done, so one request is handled at a time.
// The result waits in an output register, so the next request is taken while
// it is held; if rsp_tready stays low the commit of that next request waits.
// Reset clears TLB valid bits, ages and counters, then sweeps the page map
// clear, one entry a cycle, over all PAGE_COUNT entries; req_tready stays low
// throughout the sweep.
module tlb_lru_address_translate_unit #(
   parameter int TLB_ENTRIES = 16,
   parameter int PAGE_COUNT  = 256,
   parameter int OFFSET_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [tlbl_pkg::ADDR_BITS-1:0] req_tdata,  // [15:0] virtual_address
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [tlbl_pkg::ADDR_BITS-1:0] rsp_tdata,  // [15:0] physical_address
   output logic [tlbl_pkg::USER_BITS-1:0] rsp_tuser   // [0] tlb_hit, [1] page_fault
);

   import tlbl_pkg::*;

   localparam int FRAME_BITS = ADDR_BITS - OFFSET_BITS;
   localparam int PIB        = $clog2(PAGE_COUNT);
   localparam int IB         = $clog2(TLB_ENTRIES);
   localparam int CB         = $clog2(TLB_ENTRIES + 1);
   localparam int TW         = PIB + FRAME_BITS;
   localparam int MW         = FRAME_BITS + 1;

   localparam logic [IB-1:0]  LAST_IDX  = IB'(TLB_ENTRIES - 1);
   localparam logic [IB-1:0]  AGE_MAX   = IB'(TLB_ENTRIES - 1);
   localparam logic [CB-1:0]  FULL_CNT  = CB'(TLB_ENTRIES);
   localparam logic [PIB-1:0] LAST_PAGE = PIB'(PAGE_COUNT - 1);

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_MUL    = 7'b0000100,
      ST_MOD    = 7'b0001000,
      ST_SCAN   = 7'b0010000,
      ST_FINISH = 7'b0100000,
      ST_COMMIT = 7'b1000000
   } state_type;

   state_type             state_ff, state_in;
   logic [PIB-1:0]        clr_ff, clr_in;
   logic [IB-1:0]         idx_ff, idx_in;
   logic                  scan_vld_ff, scan_vld_in;
   logic [IB-1:0]         scan_idx_ff, scan_idx_in;
   logic                  hit_found_ff, hit_found_in;
   logic [IB-1:0]         hit_idx_ff, hit_idx_in;
   logic [IB-1:0]         hit_age_ff, hit_age_in;
   logic [FRAME_BITS-1:0] hit_frame_ff, hit_frame_in;
   logic                  vic_found_ff, vic_found_in;
   logic [IB-1:0]         vic_idx_ff, vic_idx_in;
   logic [IB-1:0]         vic_age_ff, vic_age_in;
   logic [TLB_ENTRIES-1:0] valid_ff, valid_in;
   logic [IB-1:0]         age_ff [TLB_ENTRIES];
   logic [IB-1:0]         age_in [TLB_ENTRIES];
   logic [CB-1:0]         fill_ff, fill_in;
   logic [FRAME_BITS-1:0] next_free_ff, next_free_in;
   logic [ADDR_BITS-1:0]  va_ff, va_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ADDR_BITS-1:0]  rsp_data_ff, rsp_data_in;
   logic [USER_BITS-1:0]  rsp_user_ff, rsp_user_in;

   logic [PIB-1:0]        page_q;
   logic [TW-1:0]         tlb_rd_data;
   logic [PIB-1:0]        sc_tag;
   logic [FRAME_BITS-1:0] sc_frame;
   logic                  sc_valid;
   logic [IB-1:0]         sc_age;
   logic                  sc_hit;
   logic                  sc_vic;
   logic [MW-1:0]         map_rd_data;
   logic                  map_wr_en;
   logic [PIB-1:0]        map_wr_addr;
   logic [MW-1:0]         map_wr_data;
   logic                  full;
   logic                  map_hit;
   logic                  fault;
   logic                  fill_mode;
   logic [IB-1:0]         sel_idx;
   logic [IB-1:0]         prev_age;
   logic [FRAME_BITS-1:0] sel_frame;
   logic                  commit_go;
   logic                  tlb_wr_en;

   tlbl_page_mod #(
      .OFFSET_BITS (OFFSET_BITS),
      .PAGE_COUNT  (PAGE_COUNT)
   ) u_page_mod (
      .clock    (clock),
      .page_raw (va_ff[ADDR_BITS-1:OFFSET_BITS]),
      .page     (page_q)
   );

   tlbl_ram #(
      .WIDTH (TW),
      .DEPTH (TLB_ENTRIES)
   ) u_tlb_ram (
      .clock   (clock),
      .wr_en   (tlb_wr_en),
      .wr_addr (sel_idx),
      .wr_data ({page_q, sel_frame}),
      .rd_addr (idx_ff),
      .rd_data (tlb_rd_data)
   );

   tlbl_ram #(
      .WIDTH (MW),
      .DEPTH (PAGE_COUNT)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_addr (page_q),
      .rd_data (map_rd_data)
   );

   // walk compare: first match, and oldest valid entry (lowest index on a tie)
   assign sc_tag   = tlb_rd_data[TW-1:FRAME_BITS];
   assign sc_frame = tlb_rd_data[FRAME_BITS-1:0];
   assign sc_valid = scan_vld_ff && valid_ff[scan_idx_ff];
   assign sc_age   = age_ff[scan_idx_ff];
   assign sc_hit   = sc_valid && (sc_tag == page_q) && !hit_found_ff;
   assign sc_vic   = sc_valid && (!vic_found_ff || (sc_age > vic_age_ff));

   assign full      = (fill_ff == FULL_CNT);
   assign map_hit   = map_rd_data[FRAME_BITS];
   assign fault     = !hit_found_ff && !map_hit;
   assign fill_mode = !hit_found_ff && !full;
   assign sel_idx   = hit_found_ff ? hit_idx_ff : (full ? vic_idx_ff : fill_ff[IB-1:0]);
   assign prev_age  = hit_found_ff ? hit_age_ff : vic_age_ff;
   assign sel_frame = hit_found_ff ? hit_frame_ff :
                      (map_hit ? map_rd_data[FRAME_BITS-1:0] : next_free_ff);
   assign commit_go = (state_ff == ST_COMMIT) && (!rsp_valid_ff || rsp_tready);
   assign tlb_wr_en = commit_go && !hit_found_ff;

   assign map_wr_en   = (state_ff == ST_CLEAR) || (commit_go && fault);
   assign map_wr_addr = (state_ff == ST_CLEAR) ? clr_ff : page_q;
   assign map_wr_data = (state_ff == ST_CLEAR) ? '0 : {1'b1, next_free_ff};

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      idx_in       = idx_ff;
      scan_vld_in  = 1'b0;
      scan_idx_in  = idx_ff;
      hit_found_in = hit_found_ff;
      hit_idx_in   = hit_idx_ff;
      hit_age_in   = hit_age_ff;
      hit_frame_in = hit_frame_ff;
      vic_found_in = vic_found_ff;
      vic_idx_in   = vic_idx_ff;
      vic_age_in   = vic_age_ff;
      valid_in     = valid_ff;
      age_in       = age_ff;
      fill_in      = fill_ff;
      next_free_in = next_free_ff;
      va_in        = va_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (sc_hit) begin
         hit_found_in = 1'b1;
         hit_idx_in   = scan_idx_ff;
         hit_age_in   = sc_age;
         hit_frame_in = sc_frame;
      end
      if (sc_vic) begin
         vic_found_in = 1'b1;
         vic_idx_in   = scan_idx_ff;
         vic_age_in   = sc_age;
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_in = PIB'(clr_ff + 1'b1);
            if (clr_ff == LAST_PAGE) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               va_in    = req_tdata;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_MOD;
         end
         ST_MOD: begin
            idx_in       = '0;
            hit_found_in = 1'b0;
            vic_found_in = 1'b0;
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            scan_vld_in = 1'b1;
            idx_in      = IB'(idx_ff + 1'b1);
            if (idx_ff == LAST_IDX) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (commit_go) begin
               for (int i = 0; i < TLB_ENTRIES; i++) begin
                  if ((IB'(i) != sel_idx) && valid_ff[i] &&
                      (fill_mode || (age_ff[i] < prev_age)) &&
                      (age_ff[i] != AGE_MAX)) begin
                     age_in[i] = IB'(age_ff[i] + 1'b1);
                  end
               end
               age_in[sel_idx]   = '0;
               valid_in[sel_idx] = 1'b1;
               if (fill_mode) begin
                  fill_in = CB'(fill_ff + 1'b1);
               end
               if (fault) begin
                  next_free_in = FRAME_BITS'(next_free_ff + 1'b1);
               end
               rsp_valid_in           = 1'b1;
               rsp_data_in            = {sel_frame, va_ff[OFFSET_BITS-1:0]};
               rsp_user_in[HIT_BIT]   = hit_found_ff;
               rsp_user_in[FAULT_BIT] = fault;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         idx_ff       <= '0;
         scan_vld_ff  <= 1'b0;
         hit_found_ff <= 1'b0;
         vic_found_ff <= 1'b0;
         valid_ff     <= '0;
         fill_ff      <= '0;
         next_free_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < TLB_ENTRIES; i++) begin
            age_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         idx_ff       <= idx_in;
         scan_vld_ff  <= scan_vld_in;
         hit_found_ff <= hit_found_in;
         vic_found_ff <= vic_found_in;
         valid_ff     <= valid_in;
         fill_ff      <= fill_in;
         next_free_ff <= next_free_in;
         rsp_valid_ff <= rsp_valid_in;
         age_ff       <= age_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff  <= scan_idx_in;
      hit_idx_ff   <= hit_idx_in;
      hit_age_ff   <= hit_age_in;
      hit_frame_ff <= hit_frame_in;
      vic_idx_ff   <= vic_idx_in;
      vic_age_ff   <= vic_age_in;
      va_ff        <= va_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   // entries fill in index order, so valid marks track the fill count
   a_valid_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(fill_ff))
      else $error("TLB valid marks disagree with fill count");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_CNT)
      else $error("TLB fill count beyond entry count");

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_COMMIT))
      else $error("result item raised outside commit");

   a_hit_no_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_user_ff[HIT_BIT] && rsp_user_ff[FAULT_BIT]))
      else $error("TLB hit flagged together with page fault");
`endif

endmodule
